// ===== hw/rtl/arp_pkg.sv =====
package arp_pkg;

  localparam int BYTE_W     = 8;
  localparam int MAC_W      = 48;
  localparam int IP_W       = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;

  localparam int REPLY_LEN_DEF = 60;
  localparam int QUEUE_DEPTH   = 2;

  // Frame positions of the ARP packet fields
  localparam int POS_W      = 6;
  localparam int ARP_END    = 42;
  localparam int HDR_FIRST  = 14;
  localparam int HDR_LAST   = 21;
  localparam int SMAC_FIRST = 22;
  localparam int SMAC_LAST  = 27;
  localparam int SIP_FIRST  = 28;
  localparam int SIP_LAST   = 31;
  localparam int TIP_FIRST  = 38;
  localparam int TIP_LAST   = 41;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP  = CFG_IDX_W'(1);

  // Protocol constants
  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic [15:0] HTYPE_ETH     = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  HLEN_ETH      = 8'h06;
  localparam logic [7:0]  PLEN_IPV4     = 8'h04;
  localparam logic [15:0] OP_REQUEST    = 16'h0001;
  localparam logic [15:0] OP_REPLY      = 16'h0002;

  // Expected bytes 14..21 of a request, first byte in the top bits
  localparam logic [63:0] REQ_HDR = {HTYPE_ETH, PTYPE_IPV4, HLEN_ETH, PLEN_IPV4, OP_REQUEST};

  typedef struct packed {
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [MAC_W-1:0] local_mac;
    logic [IP_W-1:0]  local_ip;
  } reply_job_t;

  // Byte idx of the reply frame; everything past the ARP packet is padding
  function automatic logic [BYTE_W-1:0] reply_byte(reply_job_t job, logic [POS_W-1:0] idx);
    logic [ARP_END*BYTE_W-1:0] frame;
    logic [POS_W-1:0]          rev;
    logic [BYTE_W-1:0]         b;
    frame = {job.sender_mac, job.local_mac, ETHERTYPE_ARP, HTYPE_ETH, PTYPE_IPV4,
             HLEN_ETH, PLEN_IPV4, OP_REPLY, job.local_mac, job.local_ip,
             job.sender_mac, job.sender_ip};
    rev = POS_W'(ARP_END - 1) - idx;
    b   = '0;
    if (idx < POS_W'(ARP_END)) begin
      b = frame[{rev, 3'b000} +: BYTE_W];
    end
    return b;
  endfunction

endpackage

// ===== hw/rtl/arp_rx_if.sv =====
interface arp_rx_if;
  import arp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              rx_last;

  modport source (output valid, output rx_byte, output rx_last, input ready);
  modport sink (input valid, input rx_byte, input rx_last, output ready);
endinterface

// ===== hw/rtl/arp_tx_if.sv =====
interface arp_tx_if;
  import arp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] tx_byte;
  logic              tx_last;

  modport source (output valid, output tx_byte, output tx_last, input ready);
  modport sink (input valid, input tx_byte, input tx_last, output ready);
endinterface

// ===== hw/rtl/arp_cfg_if.sv =====
interface arp_cfg_if;
  import arp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/arp_responder.sv =====
// ARP responder for Ethernet / IPv4.
// in_bus carries a received frame one byte per beat (rx_byte), with rx_last
// on the final byte. out_bus carries the reply frame, REPLY_LEN beats, with
// tx_last on the final one. cfg_bus writes local_mac (index 0) and
// local_ip (index 1); other indexes are ignored, and writes are always ready.
// The parser takes one byte per cycle while the reply queue is not full.
// A request whose target address matches local_ip queues a reply on its
// last byte; the reply is written to the queue, then its bytes pass the
// out_bus output register, one byte per cycle while out_bus is ready.
// The reply queue holds two replies; while it is full in_bus.ready is low,
// so a receiver that stalls out_bus eventually backs up the frame input.
// Sustained input rate is one byte per cycle as long as replies drain; the
// serializer's REPLY_LEN beats per reply bound the rate of reply traffic.
// Reset (rst_n low at a clock edge) clears both addresses to zero, empties
// the queue, drops out_bus.valid and restarts parsing at byte 0.
module arp_responder #(
  parameter int REPLY_LEN = arp_pkg::REPLY_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  arp_rx_if.sink    in_bus,
  arp_tx_if.source  out_bus,
  arp_cfg_if.sink   cfg_bus
);
  import arp_pkg::*;

  logic       push_valid;
  reply_job_t push_job;
  logic       q_full;
  logic       head_valid;
  reply_job_t head_job;
  logic       pop;

  arp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .cfg_bus    (cfg_bus),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  arp_rq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_rq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  arp_back #(
    .REPLY_LEN (REPLY_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule

// ===== hw/rtl/arp_front.sv =====
module arp_front (
  input  logic                clk,
  input  logic                rst_n,
  arp_rx_if.sink              in_bus,
  arp_cfg_if.sink             cfg_bus,
  input  logic                q_full,
  output logic                push_valid,
  output arp_pkg::reply_job_t push_job
);
  import arp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic             ip_ok_r, ip_ok_nxt;
  logic [MAC_W-1:0] smac_r, smac_nxt;
  logic [IP_W-1:0]  sip_r, sip_nxt;
  logic [MAC_W-1:0] lmac_r;
  logic [IP_W-1:0]  lip_r;
  logic [POS_W-1:0] hidx;
  logic [POS_W-1:0] tidx;
  logic             accept;
  logic             cfg_wr;

  assign in_bus.ready  = !q_full;
  assign cfg_bus.ready = 1'b1;
  assign accept        = in_bus.valid && in_bus.ready;
  assign cfg_wr        = cfg_bus.valid && cfg_bus.ready;

  // Check fixed fields and target address, capture the sender
  always_comb begin
    hdr_ok_nxt = hdr_ok_r;
    ip_ok_nxt  = ip_ok_r;
    smac_nxt   = smac_r;
    sip_nxt    = sip_r;
    hidx       = POS_W'(HDR_LAST) - pos_r;
    tidx       = POS_W'(TIP_LAST) - pos_r;
    if (pos_r inside {[HDR_FIRST:HDR_LAST]}) begin
      if (in_bus.rx_byte != REQ_HDR[{hidx[2:0], 3'b000} +: BYTE_W]) begin
        hdr_ok_nxt = 1'b0;
      end
    end else if (pos_r inside {[SMAC_FIRST:SMAC_LAST]}) begin
      smac_nxt = {smac_r[MAC_W-BYTE_W-1:0], in_bus.rx_byte};
    end else if (pos_r inside {[SIP_FIRST:SIP_LAST]}) begin
      sip_nxt = {sip_r[IP_W-BYTE_W-1:0], in_bus.rx_byte};
    end else if (pos_r inside {[TIP_FIRST:TIP_LAST]}) begin
      if (in_bus.rx_byte != lip_r[{tidx[1:0], 3'b000} +: BYTE_W]) begin
        ip_ok_nxt = 1'b0;
      end
    end
  end

  // Advance the position, saturating past the ARP packet
  always_comb begin
    pos_nxt = pos_r;
    if (in_bus.rx_last) begin
      pos_nxt = '0;
    end else if (pos_r < POS_W'(ARP_END)) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // Queue a reply on the last beat of a qualifying request
  assign push_valid = accept && in_bus.rx_last && (pos_r >= POS_W'(ARP_END - 1)) &&
                      hdr_ok_nxt && ip_ok_nxt;
  assign push_job   = '{sender_mac: smac_r, sender_ip: sip_r,
                        local_mac: lmac_r, local_ip: lip_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hdr_ok_r <= 1'b1;
      ip_ok_r  <= 1'b1;
      smac_r   <= '0;
      sip_r    <= '0;
      lmac_r   <= '0;
      lip_r    <= '0;
    end else begin
      if (accept) begin
        pos_r    <= pos_nxt;
        hdr_ok_r <= in_bus.rx_last ? 1'b1 : hdr_ok_nxt;
        ip_ok_r  <= in_bus.rx_last ? 1'b1 : ip_ok_nxt;
        smac_r   <= smac_nxt;
        sip_r    <= sip_nxt;
      end
      if (cfg_wr) begin
        case (cfg_bus.index)
          REG_LOCAL_MAC: lmac_r <= cfg_bus.data[MAC_W-1:0];
          REG_LOCAL_IP:  lip_r  <= cfg_bus.data[IP_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/arp_rq.sv =====
module arp_rq #(
  parameter int DEPTH = arp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  arp_pkg::reply_job_t push_job,
  output logic                full,
  output logic                head_valid,
  output arp_pkg::reply_job_t head_job,
  input  logic                pop
);
  import arp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  reply_job_t       slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];

  // Store the job
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/arp_back.sv =====
module arp_back #(
  parameter int REPLY_LEN = arp_pkg::REPLY_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  arp_pkg::reply_job_t head_job,
  output logic                pop,
  arp_tx_if.source            out_bus
);
  import arp_pkg::*;

  localparam int CNT_W = $clog2(REPLY_LEN);

  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] tx_byte_r;
  logic              tx_last_r;
  logic              load;
  logic              last_beat;

  assign load      = head_valid && (!out_valid_r || out_bus.ready);
  assign last_beat = (cnt_r == CNT_W'(REPLY_LEN - 1));
  assign pop       = load && last_beat;

  assign out_bus.valid   = out_valid_r;
  assign out_bus.tx_byte = tx_byte_r;
  assign out_bus.tx_last = tx_last_r;

  // Walk the reply one beat at a time, drop the valid when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      cnt_r       <= last_beat ? '0 : cnt_r + CNT_W'(1);
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte_r <= reply_byte(head_job, cnt_r[POS_W-1:0]);
      tx_last_r <= last_beat;
    end
  end

endmodule
